FILE: rtl/lpcm_pkg.sv
// ----------------------------------------------------------------------------
// lpcm_pkg
// Shared widths for the closest-point midpoint datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package lpcm_pkg;
   localparam int COORD_W = 32;
   localparam int DIR_W   = 18;
   localparam int DEN_W   = 80;
   localparam int NUM_W   = 129;
   localparam int QUO_W   = 32;
endpackage
`default_nettype wire

FILE: rtl/line_pair_closest_midpoint_unit.sv
// ----------------------------------------------------------------------------
// line_pair_closest_midpoint_unit
// Midpoint of the closest points of two 3D lines, fully pipelined.
//
//   channel  ports                  direction  handshake
//   request  start, busy, req_*     in         beat when start && !busy
//   result   rsp_valid, rsp_*       out        one-cycle strobe, no stall
//
// One ray pair is accepted every cycle. The pipeline holds the
// digit-serial multipliers (4 and 6 stages) and the 32 quotient-bit
// stages of the divider.
// Reset clears only the valid line; busy is always low and the result
// side never stalls, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module line_pair_closest_midpoint_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [lpcm_pkg::COORD_W-1:0] req_a_base_x,
   input  wire logic signed [lpcm_pkg::COORD_W-1:0] req_a_base_y,
   input  wire logic signed [lpcm_pkg::COORD_W-1:0] req_a_base_z,
   input  wire logic signed [lpcm_pkg::DIR_W-1:0]   req_a_dir_x,
   input  wire logic signed [lpcm_pkg::DIR_W-1:0]   req_a_dir_y,
   input  wire logic signed [lpcm_pkg::DIR_W-1:0]   req_a_dir_z,
   input  wire logic signed [lpcm_pkg::COORD_W-1:0] req_b_base_x,
   input  wire logic signed [lpcm_pkg::COORD_W-1:0] req_b_base_y,
   input  wire logic signed [lpcm_pkg::COORD_W-1:0] req_b_base_z,
   input  wire logic signed [lpcm_pkg::DIR_W-1:0]   req_b_dir_x,
   input  wire logic signed [lpcm_pkg::DIR_W-1:0]   req_b_dir_y,
   input  wire logic signed [lpcm_pkg::DIR_W-1:0]   req_b_dir_z,
   output logic                                     rsp_valid,
   output logic signed [lpcm_pkg::COORD_W-1:0]      rsp_mid_x,
   output logic signed [lpcm_pkg::COORD_W-1:0]      rsp_mid_y,
   output logic signed [lpcm_pkg::COORD_W-1:0]      rsp_mid_z,
   output logic                                     rsp_degenerate
);
   import lpcm_pkg::*;

   localparam int LATENCY = 50;
   localparam int W0_W  = COORD_W + 1;
   localparam int DD_W  = 2 * DIR_W;
   localparam int DW0_W = DIR_W + W0_W;
   localparam int ABC_W = DD_W + 1;
   localparam int DE_W  = DW0_W + 2;
   localparam int P4_W  = ABC_W + DE_W;
   localparam int NS_W  = P4_W + 1;
   localparam int DB_W  = DEN_W + 1;
   localparam int PS_W  = W0_W + DB_W;
   localparam int PU_W  = DIR_W + NS_W;
   localparam int N_W   = NUM_W - 1;
   localparam int SIDE_W = W0_W + 2 * DIR_W;

   logic [LATENCY-1:0] valid_ff;
   logic [LATENCY-1:0] valid_in;

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   logic signed [W0_W-1:0]  w0_ff [3];
   logic signed [W0_W-1:0]  s_ff  [3];
   logic signed [DIR_W-1:0] u_ff  [3];
   logic signed [DIR_W-1:0] v_ff  [3];
   logic signed [COORD_W-1:0] pa [3];
   logic signed [COORD_W-1:0] pb [3];
   logic signed [DIR_W-1:0]   ui [3];
   logic signed [DIR_W-1:0]   vi [3];

   assign pa = '{req_a_base_x, req_a_base_y, req_a_base_z};
   assign pb = '{req_b_base_x, req_b_base_y, req_b_base_z};
   assign ui = '{req_a_dir_x, req_a_dir_y, req_a_dir_z};
   assign vi = '{req_b_dir_x, req_b_dir_y, req_b_dir_z};

   logic signed [DD_W-1:0]  uu_ff [3];
   logic signed [DD_W-1:0]  uv_ff [3];
   logic signed [DD_W-1:0]  vv_ff [3];
   logic signed [DW0_W-1:0] uw_ff [3];
   logic signed [DW0_W-1:0] vw_ff [3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         w0_ff[i] <= W0_W'(pa[i]) - W0_W'(pb[i]);
         s_ff[i]  <= W0_W'(pa[i]) + W0_W'(pb[i]);
         u_ff[i]  <= ui[i];
         v_ff[i]  <= vi[i];
         uu_ff[i] <= u_ff[i] * u_ff[i];
         uv_ff[i] <= u_ff[i] * v_ff[i];
         vv_ff[i] <= v_ff[i] * v_ff[i];
         uw_ff[i] <= u_ff[i] * w0_ff[i];
         vw_ff[i] <= v_ff[i] * w0_ff[i];
      end
   end

   logic signed [ABC_W-1:0] a_ff, b_ff, c_ff;
   logic signed [DE_W-1:0]  d_ff, e_ff;

   always_ff @(posedge clock) begin
      a_ff <= ABC_W'(uu_ff[0]) + ABC_W'(uu_ff[1]) + ABC_W'(uu_ff[2]);
      b_ff <= ABC_W'(uv_ff[0]) + ABC_W'(uv_ff[1]) + ABC_W'(uv_ff[2]);
      c_ff <= ABC_W'(vv_ff[0]) + ABC_W'(vv_ff[1]) + ABC_W'(vv_ff[2]);
      d_ff <= DE_W'(uw_ff[0]) + DE_W'(uw_ff[1]) + DE_W'(uw_ff[2]);
      e_ff <= DE_W'(vw_ff[0]) + DE_W'(vw_ff[1]) + DE_W'(vw_ff[2]);
   end

   logic signed [P4_W-1:0] ac_p, bb_p, be_p, cd_p, ae_p, bd_p;

   lpcm_mul #(.AW(ABC_W), .BW(DE_W), .DW(16)) u_mul_ac (
      .clock(clock), .mul_a(a_ff), .mul_b(DE_W'(c_ff)), .mul_p(ac_p));
   lpcm_mul #(.AW(ABC_W), .BW(DE_W), .DW(16)) u_mul_bb (
      .clock(clock), .mul_a(b_ff), .mul_b(DE_W'(b_ff)), .mul_p(bb_p));
   lpcm_mul #(.AW(ABC_W), .BW(DE_W), .DW(16)) u_mul_be (
      .clock(clock), .mul_a(b_ff), .mul_b(e_ff), .mul_p(be_p));
   lpcm_mul #(.AW(ABC_W), .BW(DE_W), .DW(16)) u_mul_cd (
      .clock(clock), .mul_a(c_ff), .mul_b(d_ff), .mul_p(cd_p));
   lpcm_mul #(.AW(ABC_W), .BW(DE_W), .DW(16)) u_mul_ae (
      .clock(clock), .mul_a(a_ff), .mul_b(e_ff), .mul_p(ae_p));
   lpcm_mul #(.AW(ABC_W), .BW(DE_W), .DW(16)) u_mul_bd (
      .clock(clock), .mul_a(b_ff), .mul_b(d_ff), .mul_p(bd_p));

   logic signed [P4_W-1:0] den_full;
   logic [DEN_W-1:0]       den_ff;
   logic                   zero_ff;
   logic signed [NS_W-1:0] nums_ff, numt_ff;

   assign den_full = ac_p - bb_p;

   always_ff @(posedge clock) begin
      den_ff  <= den_full[DEN_W-1:0];
      zero_ff <= (den_full == '0);
      nums_ff <= NS_W'(be_p) - NS_W'(cd_p);
      numt_ff <= NS_W'(ae_p) - NS_W'(bd_p);
   end

   logic [SIDE_W-1:0] side_q [3];
   logic signed [PS_W-1:0] ps_p [3];
   logic signed [PU_W-1:0] pu_p [3];
   logic signed [PU_W-1:0] pv_p [3];
   logic signed [N_W-1:0]  n_ff [3];

   for (genvar i = 0; i < 3; i++) begin : g_axis
      logic signed [W0_W-1:0]  s_d;
      logic signed [DIR_W-1:0] u_d;
      logic signed [DIR_W-1:0] v_d;

      lpcm_delay #(.W(SIDE_W), .N(7)) u_side (
         .clock(clock), .dly_d({s_ff[i], u_ff[i], v_ff[i]}), .dly_q(side_q[i]));

      assign {s_d, u_d, v_d} = side_q[i];

      lpcm_mul #(.AW(W0_W), .BW(DB_W), .DW(16)) u_mul_s (
         .clock(clock), .mul_a(s_d), .mul_b($signed({1'b0, den_ff})), .mul_p(ps_p[i]));
      lpcm_mul #(.AW(DIR_W), .BW(NS_W), .DW(16)) u_mul_u (
         .clock(clock), .mul_a(u_d), .mul_b(nums_ff), .mul_p(pu_p[i]));
      lpcm_mul #(.AW(DIR_W), .BW(NS_W), .DW(16)) u_mul_v (
         .clock(clock), .mul_a(v_d), .mul_b(numt_ff), .mul_p(pv_p[i]));

      always_ff @(posedge clock) begin
         n_ff[i] <= N_W'(ps_p[i]) + N_W'(pu_p[i]) + N_W'(pv_p[i]);
      end
   end

   logic [DEN_W:0]   dz_q;
   logic [DEN_W-1:0] den_e;
   logic             zero_e;

   lpcm_delay #(.W(DEN_W + 1), .N(7)) u_den_dly (
      .clock(clock), .dly_d({zero_ff, den_ff}), .dly_q(dz_q));

   assign {zero_e, den_e} = dz_q;

   logic [NUM_W-1:0] num_ff [3];
   logic             neg_ff [3];
   logic [DEN_W-1:0] den_f_ff;
   logic             zero_f_ff;
   logic [COORD_W-1:0] res [3];
   logic               flag [3];

   always_ff @(posedge clock) begin
      den_f_ff  <= den_e;
      zero_f_ff <= zero_e;
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      logic [N_W-1:0] mag;
      assign mag = n_ff[i][N_W-1] ? (N_W'(0) - n_ff[i]) : n_ff[i];

      always_ff @(posedge clock) begin
         neg_ff[i] <= n_ff[i][N_W-1];
         num_ff[i] <= NUM_W'(mag) + NUM_W'(den_e);
      end

      lpcm_div u_div (
         .clock(clock), .div_num(num_ff[i]), .div_den(den_f_ff),
         .div_neg(neg_ff[i]), .div_zero(zero_f_ff),
         .div_res(res[i]), .div_flag(flag[i]));
   end

   assign rsp_valid      = valid_ff[LATENCY-1];
   assign rsp_mid_x      = res[0];
   assign rsp_mid_y      = res[1];
   assign rsp_mid_z      = res[2];
   assign rsp_degenerate = flag[0] | flag[1] | flag[2];
endmodule
`default_nettype wire

FILE: rtl/lpcm_delay.sv
// ----------------------------------------------------------------------------
// lpcm_delay
// Fixed-length shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module lpcm_delay #(
   parameter int W = 8,
   parameter int N = 1
) (
   input  wire logic         clock,
   input  wire logic [W-1:0] dly_d,
   output logic      [W-1:0] dly_q
);
   logic [W-1:0] dly_ff [N];

   always_ff @(posedge clock) begin
      dly_ff[0] <= dly_d;
      for (int i = 1; i < N; i++) begin
         dly_ff[i] <= dly_ff[i-1];
      end
   end

   assign dly_q = dly_ff[N-1];
endmodule
`default_nettype wire

FILE: rtl/lpcm_mul.sv
// ----------------------------------------------------------------------------
// lpcm_mul
// Pipelined signed multiplier that takes one digit of the second operand
// per stage and accumulates the shifted partial products.
// ----------------------------------------------------------------------------
`default_nettype none
module lpcm_mul #(
   parameter int AW = 18,
   parameter int BW = 32,
   parameter int DW = 16
) (
   input  wire logic                    clock,
   input  wire logic signed [AW-1:0]    mul_a,
   input  wire logic signed [BW-1:0]    mul_b,
   output logic      signed [AW+BW-1:0] mul_p
);
   localparam int ND  = (BW + DW - 1) / DW;
   localparam int BPW = ND * DW;
   localparam int PW  = AW + BW;

   logic signed [AW-1:0] a_ff   [ND];
   logic        [BPW-1:0] b_ff  [ND];
   logic signed [PW-1:0] acc_ff [ND];

   for (genvar i = 0; i < ND; i++) begin : g_stage
      logic signed [AW-1:0]  a_src;
      logic        [BPW-1:0] b_src;
      logic signed [PW-1:0]  acc_src;
      logic signed [DW:0]    dig;
      logic signed [AW+DW:0] prod;
      logic signed [PW-1:0]  acc_in;

      if (i == 0) begin : g_first
         assign a_src   = mul_a;
         assign b_src   = BPW'(mul_b);
         assign acc_src = '0;
      end else begin : g_next
         assign a_src   = a_ff[i-1];
         assign b_src   = b_ff[i-1];
         assign acc_src = acc_ff[i-1];
      end

      if (i == ND - 1) begin : g_top
         assign dig = $signed({b_src[i*DW+DW-1], b_src[i*DW +: DW]});
      end else begin : g_low
         assign dig = $signed({1'b0, b_src[i*DW +: DW]});
      end

      assign prod   = a_src * dig;
      assign acc_in = acc_src + (PW'(prod) <<< (i * DW));

      always_ff @(posedge clock) begin
         a_ff[i]   <= a_src;
         b_ff[i]   <= b_src;
         acc_ff[i] <= acc_in;
      end
   end

   assign mul_p = acc_ff[ND-1];
endmodule
`default_nettype wire

FILE: rtl/lpcm_div.sv
// ----------------------------------------------------------------------------
// lpcm_div
// Pipelined restoring divider with rounding and saturation for one
// coordinate: one quotient bit per stage, range check up front.
// ----------------------------------------------------------------------------
`default_nettype none
module lpcm_div (
   input  wire logic                         clock,
   input  wire logic [lpcm_pkg::NUM_W-1:0]   div_num,
   input  wire logic [lpcm_pkg::DEN_W-1:0]   div_den,
   input  wire logic                         div_neg,
   input  wire logic                         div_zero,
   output logic      [lpcm_pkg::COORD_W-1:0] div_res,
   output logic                              div_flag
);
   import lpcm_pkg::*;

   localparam int DV_W = DEN_W + 1;
   localparam logic [QUO_W-1:0] MIN_MAG = {1'b1, {(QUO_W-1){1'b0}}};
   localparam logic [COORD_W-1:0] POS_SAT = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] NEG_SAT = {1'b1, {(COORD_W-1){1'b0}}};

   logic [NUM_W-1:0] rem_ff  [QUO_W+1];
   logic [DV_W-1:0]  dv_ff   [QUO_W+1];
   logic [QUO_W-1:0] q_ff    [QUO_W+1];
   logic             ovf_ff  [QUO_W+1];
   logic             neg_ff  [QUO_W+1];
   logic             zero_ff [QUO_W+1];
   logic [COORD_W-1:0] res_ff;
   logic               flag_ff;
   logic [COORD_W-1:0] res_in;
   logic               flag_in;
   logic [DV_W-1:0]    dv_in;

   assign dv_in = {div_den, 1'b0};

   always_ff @(posedge clock) begin
      rem_ff[0]  <= div_num;
      dv_ff[0]   <= dv_in;
      q_ff[0]    <= '0;
      ovf_ff[0]  <= (div_num >= (NUM_W'(dv_in) << QUO_W));
      neg_ff[0]  <= div_neg;
      zero_ff[0] <= div_zero;
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [NUM_W-1:0] sh;
      logic             take;
      assign sh   = NUM_W'(dv_ff[k-1]) << (QUO_W - k);
      assign take = (rem_ff[k-1] >= sh);
      always_ff @(posedge clock) begin
         rem_ff[k]  <= take ? (rem_ff[k-1] - sh) : rem_ff[k-1];
         dv_ff[k]   <= dv_ff[k-1];
         q_ff[k]    <= q_ff[k-1] | (QUO_W'(take) << (QUO_W - k));
         ovf_ff[k]  <= ovf_ff[k-1];
         neg_ff[k]  <= neg_ff[k-1];
         zero_ff[k] <= zero_ff[k-1];
      end
   end

   always_comb begin
      res_in  = q_ff[QUO_W];
      flag_in = 1'b0;
      if (zero_ff[QUO_W]) begin
         res_in  = '0;
         flag_in = 1'b1;
      end else if (neg_ff[QUO_W]) begin
         if (ovf_ff[QUO_W] || (q_ff[QUO_W] > MIN_MAG)) begin
            res_in  = NEG_SAT;
            flag_in = 1'b1;
         end else begin
            res_in = COORD_W'(0) - q_ff[QUO_W];
         end
      end else if (ovf_ff[QUO_W] || q_ff[QUO_W][QUO_W-1]) begin
         res_in  = POS_SAT;
         flag_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      flag_ff <= flag_in;
   end

   assign div_res  = res_ff;
   assign div_flag = flag_ff;
endmodule
`default_nettype wire
